// ===== hw/rtl/crc8_word_framer_assert.svh =====
// assertion helpers for the crc8 word framer, clocked on clk and disabled in reset
`ifndef CRC8_WORD_FRAMER_ASSERT_SVH
`define CRC8_WORD_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define CRCWF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("crc8 word framer check failed");
`define CRCWF_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
`else
`define CRCWF_ASSERT(lbl, prop)
`define CRCWF_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/crcwf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package crcwf_pkg;

	localparam logic [7:0] CrcPolyReset = 8'h31;
	localparam logic [7:0] CrcSeedReset = 8'hFF;

	localparam logic [0:0] REG_CRC_POLY = 1'b0;
	localparam logic [0:0] REG_CRC_SEED = 1'b1;

	localparam logic FUNC_TX = 1'b0;
	localparam logic FUNC_RX = 1'b1;

	localparam logic KIND_TX = 1'b0;
	localparam logic KIND_RX = 1'b1;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef struct packed {
		logic        is_rx;
		logic [15:0] data;
		logic        crc_error;
		logic        any_error;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// one byte through the crc, msb first
	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data,
		input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ((c << 1) ^ poly) : (c << 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crcwf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crcwf_queue
	import crcwf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  q_entry_t       wr_entry,
	input  wire logic      rd_en,
	output q_entry_t       rd_entry,
	output q_status_t      status
);

	q_entry_t              mem_q [QDepth];
	logic [QPtrW-1:0]      wr_ptr_q;
	logic [QPtrW-1:0]      rd_ptr_q;
	logic [QCntW-1:0]      count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_entry     = mem_q[rd_ptr_q];
	assign status.full  = (count_q == QCntW'(QDepth));
	assign status.empty = (count_q == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/crcwf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module crcwf_front
	import crcwf_pkg::*;
#(
	parameter int WORD_BYTES = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic        func,
	input  wire logic [15:0] tx_word,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        restart,
	input  wire logic [7:0]  crc_poly,
	input  wire logic [7:0]  crc_seed,
	output logic             wr_en,
	output q_entry_t         wr_entry
);

	localparam int PosW = $clog2(WORD_BYTES + 1);

	logic [PosW-1:0] pos_q;
	logic [7:0]      crc_q;
	logic [15:0]     word_q;
	logic            sticky_q;

	logic [PosW-1:0] pos_eff;
	logic [15:0]     word_eff;
	logic            sticky_eff;
	logic            at_check;
	logic [7:0]      crc_base;
	logic [7:0]      crc_nx;
	logic            mismatch;
	logic            rx_take;

	always_comb begin
		// a restart clears the receive side before the byte is taken
		pos_eff    = restart ? '0 : pos_q;
		word_eff   = restart ? '0 : word_q;
		sticky_eff = restart ? 1'b0 : sticky_q;
		at_check   = (pos_eff == PosW'(WORD_BYTES));
		crc_base   = (pos_eff == '0) ? crc_seed : crc_q;
		crc_nx     = crc8_feed(crc_base, rx_byte, crc_poly);
		mismatch   = (crc_q != rx_byte);
		rx_take    = accept && (func == FUNC_RX);

		wr_en              = accept && ((func == FUNC_TX) || at_check);
		wr_entry.is_rx     = (func == FUNC_RX);
		wr_entry.data      = (func == FUNC_RX) ? word_q : tx_word;
		wr_entry.crc_error = mismatch;
		wr_entry.any_error = sticky_eff | mismatch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			crc_q    <= CrcSeedReset;
			word_q   <= '0;
			sticky_q <= 1'b0;
		end else if (rx_take) begin
			if (!at_check) begin
				crc_q    <= crc_nx;
				word_q   <= (pos_eff == '0) ? {8'h00, rx_byte} : {word_eff[7:0], rx_byte};
				pos_q    <= pos_eff + 1'b1;
				sticky_q <= sticky_eff;
			end else begin
				crc_q    <= crc_seed;
				word_q   <= '0;
				pos_q    <= '0;
				sticky_q <= sticky_eff | mismatch;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/crcwf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "crc8_word_framer_assert.svh"

module crcwf_back
	import crcwf_pkg::*;
#(
	parameter int WORD_BYTES = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  q_entry_t         head,
	input  q_status_t        q_status,
	output logic             q_pop,
	input  wire logic [7:0]  crc_poly,
	input  wire logic [7:0]  crc_seed,
	input  wire logic        pop,
	output logic             empty,
	output logic             kind,
	output logic [15:0]      payload,
	output logic             crc_error,
	output logic             any_error,
	output logic             last
);

	localparam int CntW = $clog2(WORD_BYTES + 1);

	logic [CntW-1:0] cnt_q;
	logic [7:0]      crc_q;
	logic            out_valid_q;
	logic            kind_q;
	logic [15:0]     payload_q;
	logic            crc_error_q;
	logic            any_error_q;
	logic            last_q;

	logic            have;
	logic            adv;
	logic            is_crc_byte;
	logic [7:0]      tx_byte;
	logic [7:0]      crc_in;
	logic [7:0]      crc_nx;

	always_comb begin
		have        = !q_status.empty;
		adv         = !out_valid_q || pop;
		is_crc_byte = (cnt_q == CntW'(WORD_BYTES));
		// data bytes go out msb first; bytes above the 16-bit word are zero
		if (int'(cnt_q) + 1 == WORD_BYTES) begin
			tx_byte = head.data[7:0];
		end else if (int'(cnt_q) + 2 == WORD_BYTES) begin
			tx_byte = head.data[15:8];
		end else begin
			tx_byte = 8'h00;
		end
		crc_in = (cnt_q == '0) ? crc_seed : crc_q;
		crc_nx = crc8_feed(crc_in, tx_byte, crc_poly);
		q_pop  = adv && have && (head.is_rx || is_crc_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			crc_q       <= CrcSeedReset;
		end else if (adv) begin
			out_valid_q <= have;
			if (have && !head.is_rx) begin
				cnt_q <= is_crc_byte ? '0 : cnt_q + 1'b1;
				crc_q <= crc_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && have) begin
			if (head.is_rx) begin
				kind_q      <= KIND_RX;
				payload_q   <= head.data;
				crc_error_q <= head.crc_error;
				any_error_q <= head.any_error;
				last_q      <= 1'b1;
			end else begin
				kind_q      <= KIND_TX;
				payload_q   <= {8'h00, is_crc_byte ? crc_q : tx_byte};
				crc_error_q <= 1'b0;
				any_error_q <= 1'b0;
				last_q      <= is_crc_byte;
			end
		end
	end

	assign empty     = !out_valid_q;
	assign kind      = kind_q;
	assign payload   = payload_q;
	assign crc_error = crc_error_q;
	assign any_error = any_error_q;
	assign last      = last_q;

	`CRCWF_ASSERT(a_cnt_range, cnt_q <= CntW'(WORD_BYTES))
	`CRCWF_ASSERT(a_frame_has_head, cnt_q != '0 |-> have && !head.is_rx)
	`CRCWF_ASSERT_MSG(a_result_held, out_valid_q && !pop |=> out_valid_q, "result dropped")
	`CRCWF_ASSERT(a_rx_last, out_valid_q && kind_q == KIND_RX |-> last_q && !crc_error_q || any_error_q)

endmodule

`default_nettype wire

// ===== hw/rtl/crc8_word_framer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// CRC-8 word framer. A transmit item (func 0) takes one 16-bit word and gives WORD_BYTES+1
// bytes, msb first, the last one the crc byte with last set; a receive item (func 1) takes
// one byte, and every WORD_BYTES+1-th byte gives the assembled word with its crc error and
// the sticky error of the transfer, which restart clears. The front side takes one item per
// cycle unless full and classifies it, doing the receive crc there; a 4-entry queue
// separates it from the back side, which sends out one result per cycle unless pop holds
// it off, so a transmit item gives WORD_BYTES+1 results and a received word one. The crc
// advances one byte per cycle unless stalled. The oldest result is on the result ports
// while empty is low. Write crc_poly/crc_seed via cfg_we/cfg_index/cfg_wdata only while idle; not enforced.
module crc8_word_framer
	import crcwf_pkg::*;
#(
	parameter int WORD_BYTES = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        push,
	output logic             full,
	input  wire logic        func,
	input  wire logic [15:0] tx_word,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        restart,
	input  wire logic        pop,
	output logic             empty,
	output logic             kind,
	output logic [15:0]      payload,
	output logic             crc_error,
	output logic             any_error,
	output logic             last
);

	logic [7:0] crc_poly_q;
	logic [7:0] crc_seed_q;

	logic       accept;
	logic       wr_en;
	q_entry_t   wr_entry;
	q_entry_t   head;
	q_status_t  q_status;
	logic       q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q <= CrcPolyReset;
			crc_seed_q <= CrcSeedReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CRC_POLY: crc_poly_q <= cfg_wdata;
				REG_CRC_SEED: crc_seed_q <= cfg_wdata;
				default:      crc_poly_q <= crc_poly_q;
			endcase
		end
	end

	assign full   = q_status.full;
	assign accept = push && !q_status.full;

	crcwf_front #(
		.WORD_BYTES(WORD_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.func     (func),
		.tx_word  (tx_word),
		.rx_byte  (rx_byte),
		.restart  (restart),
		.crc_poly (crc_poly_q),
		.crc_seed (crc_seed_q),
		.wr_en    (wr_en),
		.wr_entry (wr_entry)
	);

	crcwf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_entry (wr_entry),
		.rd_en    (q_pop),
		.rd_entry (head),
		.status   (q_status)
	);

	crcwf_back #(
		.WORD_BYTES(WORD_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.q_pop     (q_pop),
		.crc_poly  (crc_poly_q),
		.crc_seed  (crc_seed_q),
		.pop       (pop),
		.empty     (empty),
		.kind      (kind),
		.payload   (payload),
		.crc_error (crc_error),
		.any_error (any_error),
		.last      (last)
	);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import crcwf_pkg::*;

	localparam int WordBytes = 2;
	localparam int CycleLimit = 300000;
	localparam int SettleCycles = 12;
	localparam int HoldCycles = 80;

	typedef struct packed {
		logic        kind;
		logic [15:0] payload;
		logic        crc_error;
		logic        any_error;
		logic        last;
	} framer_result_t;

	// predicts the framer: transmit triplets and checked receive words
	class framer_scoreboard;
		logic [7:0] poly;
		logic [7:0] seed;
		logic [7:0] rx_crc;
		logic [1:0] rx_pos;
		logic [15:0] rx_word;
		logic sticky;
		framer_result_t expected_q[$];
		int failures;

		function new();
			poly = CrcPolyReset;
			seed = CrcSeedReset;
			rx_crc = CrcSeedReset;
			rx_pos = '0;
			rx_word = '0;
			sticky = 1'b0;
			failures = 0;
		endfunction

		function logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
			logic [7:0] c;
			c = crc ^ data;
			repeat (8) begin
				if (c[7]) c = {c[6:0], 1'b0} ^ poly;
				else c = {c[6:0], 1'b0};
			end
			return c;
		endfunction

		// crc byte that a sender would append to a fresh word
		function logic [7:0] word_crc(input logic [15:0] w);
			return crc_step(crc_step(seed, w[15:8]), w[7:0]);
		endfunction

		function void set_reg(input logic [0:0] idx, input logic [7:0] val);
			if (idx == REG_CRC_POLY) poly = val;
			else if (idx == REG_CRC_SEED) seed = val;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_item(input logic f, input logic [15:0] w, input logic [7:0] b,
			input logic r);
			logic [7:0] crc;
			logic [7:0] tx_b;
			logic err;
			if (f == FUNC_TX) begin
				crc = seed;
				for (int i = WordBytes - 1; i >= 0; i--) begin
					tx_b = (i < 2) ? w[8*i +: 8] : 8'h00;
					crc = crc_step(crc, tx_b);
					expected_q.push_back('{KIND_TX, {8'h00, tx_b}, 1'b0, 1'b0, 1'b0});
				end
				expected_q.push_back('{KIND_TX, {8'h00, crc}, 1'b0, 1'b0, 1'b1});
				return;
			end
			if (r) begin
				rx_pos = '0;
				rx_word = '0;
				sticky = 1'b0;
			end
			if (rx_pos < WordBytes) begin
				if (rx_pos == 0) begin
					rx_crc = seed;
					rx_word = '0;
				end
				rx_crc = crc_step(rx_crc, b);
				rx_word = {rx_word[7:0], b};
				rx_pos = rx_pos + 2'd1;
			end else begin
				err = (rx_crc != b);
				sticky = sticky | err;
				expected_q.push_back('{KIND_RX, rx_word, err, sticky, 1'b1});
				rx_pos = '0;
				rx_crc = seed;
				rx_word = '0;
			end
		endfunction

		function void check_result(input logic k, input logic [15:0] p, input logic ce,
			input logic ae, input logic l);
			framer_result_t exp_r;
			if (expected_q.size() == 0) begin
				$error("unexpected result: kind %0d payload %h", k, p);
				failures++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (exp_r.kind !== k) begin
				$error("kind: expected %0d, got %0d", exp_r.kind, k);
				failures++;
			end
			if (exp_r.payload !== p) begin
				$error("payload: expected %h, got %h", exp_r.payload, p);
				failures++;
			end
			if (exp_r.crc_error !== ce) begin
				$error("crc_error: expected %0d, got %0d", exp_r.crc_error, ce);
				failures++;
			end
			if (exp_r.any_error !== ae) begin
				$error("any_error: expected %0d, got %0d", exp_r.any_error, ae);
				failures++;
			end
			if (exp_r.last !== l) begin
				$error("last: expected %0d, got %0d", exp_r.last, l);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_wdata;
	logic push;
	logic full;
	logic func;
	logic [15:0] tx_word;
	logic [7:0] rx_byte;
	logic restart;
	logic pop;
	logic empty;
	logic kind;
	logic [15:0] payload;
	logic crc_error;
	logic any_error;
	logic last;

	framer_scoreboard sb;
	int items_sent;
	int cycles;
	bit tx_calm;
	bit rx_calm;
	bit hold_req;

	crc8_word_framer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.push(push),
		.full(full),
		.func(func),
		.tx_word(tx_word),
		.rx_byte(rx_byte),
		.restart(restart),
		.pop(pop),
		.empty(empty),
		.kind(kind),
		.payload(payload),
		.crc_error(crc_error),
		.any_error(any_error),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// called and returns at a falling edge
	task automatic send_item(input logic f, input logic [15:0] w, input logic [7:0] b,
		input logic r);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) repeat (gap) @(negedge clk);
		push = 1'b1;
		func = f;
		tx_word = w;
		rx_byte = b;
		restart = r;
		do @(posedge clk); while (full);
		sb.note_item(f, w, b, r);
		items_sent++;
		@(negedge clk);
		push = 1'b0;
	endtask

	// unused fields carry random junk
	task automatic send_tx(input logic [15:0] w, input logic r);
		send_item(FUNC_TX, w, 8'($urandom), r);
	endtask

	task automatic send_rx(input logic [7:0] b, input logic r);
		send_item(FUNC_RX, 16'($urandom), b, r);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic wait_idle();
		while (sb.pending() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	// a transfer of well-formed words, some with a corrupted crc byte
	task automatic send_transfer(input int words);
		logic [15:0] w;
		logic [7:0] c;
		for (int i = 0; i < words; i++) begin
			w = 16'($urandom);
			c = sb.word_crc(w);
			if ($urandom_range(0, 99) < 15) c = c ^ 8'($urandom_range(1, 255));
			send_rx(w[15:8], i == 0);
			if ($urandom_range(0, 99) < 10) send_tx(16'($urandom), 1'($urandom));
			send_rx(w[7:0], 1'b0);
			send_rx(c, 1'b0);
		end
	endtask

	task automatic run_random(input int n);
		int target;
		int r;
		target = items_sent + n;
		while (items_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				send_tx(16'($urandom), 1'($urandom));
			end else if (r < 85) begin
				send_transfer($urandom_range(1, 4));
			end else begin
				repeat ($urandom_range(1, 4))
					send_rx(8'($urandom), $urandom_range(0, 99) < 25);
			end
		end
	endtask

	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			int gap;
			gap = hold_req ? HoldCycles : (rx_calm ? 0 : pick_gap());
			hold_req = 1'b0;
			if (gap > 0) begin
				pop = 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop = 1'b1;
			do @(posedge clk); while (empty);
			sb.check_result(kind, payload, crc_error, any_error, last);
			@(negedge clk);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [7:0] p_val;
		logic [7:0] s_val;
		sb = new();
		items_sent = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CRC_POLY;
		cfg_wdata = 8'h00;
		push = 1'b0;
		func = FUNC_TX;
		tx_word = 16'h0000;
		rx_byte = 8'h00;
		restart = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: transmit extremes, restart ignored on transmit
		send_tx(16'h0000, 1'b0);
		send_tx(16'hFFFF, 1'b1);
		send_tx(16'hBEEF, 1'b1);
		// good word opening a transfer
		send_rx(8'hBE, 1'b1);
		send_rx(8'hEF, 1'b0);
		send_rx(sb.word_crc(16'hBEEF), 1'b0);
		// bad crc sets the sticky flag, which then holds over a good word
		send_rx(8'h00, 1'b0);
		send_rx(8'h00, 1'b0);
		send_rx(sb.word_crc(16'h0000) ^ 8'h01, 1'b0);
		send_rx(8'hFF, 1'b0);
		send_rx(8'hFF, 1'b0);
		send_rx(sb.word_crc(16'hFFFF), 1'b0);
		// transmit in the middle of a received word leaves it intact
		send_rx(8'h12, 1'b0);
		send_tx(16'h1234, 1'b1);
		send_rx(8'h34, 1'b0);
		send_rx(sb.word_crc(16'h1234), 1'b0);
		// restart in the middle of a word
		send_rx(8'hAA, 1'b1);
		send_rx(8'h55, 1'b1);
		send_rx(8'h66, 1'b0);
		send_rx(sb.word_crc(16'h5566), 1'b0);
		// leave a word half done across the register change below
		send_rx(8'h3C, 1'b1);

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			case (p)
				0: begin p_val = 8'h07; s_val = 8'h00; end
				1: begin p_val = 8'h00; s_val = 8'h00; end
				2: begin p_val = 8'hFF; s_val = 8'hFF; end
				3: begin p_val = CrcPolyReset; s_val = CrcSeedReset; end
				default: begin p_val = 8'($urandom); s_val = 8'($urandom); end
			endcase
			write_reg(REG_CRC_POLY, p_val);
			write_reg(REG_CRC_SEED, s_val);
			tx_calm = (p == 4);
			rx_calm = (p == 1) || (p == 4);
			if (p == 0) begin
				// old seed already in the running crc, new polynomial from here on
				send_rx(8'hC3, 1'b0);
				send_rx(sb.rx_crc, 1'b0);
			end
			if (p == 2) begin
				// receiver holds off while the sender keeps pushing
				hold_req = 1'b1;
				tx_calm = 1'b1;
				repeat (12) send_tx(16'($urandom), 1'($urandom));
				tx_calm = 1'b0;
			end
			run_random(40);
		end

		wait_idle();
		if (sb.failures == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule
